// File: rtl/core/encpd_pkg.sv
// Shared types and constants for the encoder PD position drive.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package encpd_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned ValW      = 24;
  localparam int unsigned DutyW     = 8;

  // Command codes carried by an input item; code 3 is unused and changes nothing.
  typedef enum logic [CmdW-1:0] {
    CMD_EDGE    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET    = 3'd0,
    REG_PROP_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_STOP_THR  = 3'd3,
    REG_MIN_DUTY  = 3'd4,
    REG_MAX_DUTY  = 3'd5
  } reg_idx_e;

  localparam logic signed [15:0] TargetRst  = 16'sd799;
  localparam logic [11:0]        PropGainRst = 12'd205;
  localparam logic [11:0]        DerivGainRst = 12'd256;
  localparam logic [7:0]         StopThrRst = 8'd10;
  localparam logic [7:0]         MinDutyRst = 8'd100;
  localparam logic [7:0]         MaxDutyRst = 8'd200;

  localparam int ValMax = 8388607;
  localparam int ValMin = -8388608;

  typedef struct packed {
    logic signed [15:0] target_counts;
    logic [11:0]        prop_gain;
    logic [11:0]        deriv_gain;
    logic [7:0]         stop_threshold;
    logic [7:0]         min_duty;
    logic [7:0]         max_duty;
  } cfg_t;

  // Outcome of one PD step.
  typedef struct packed {
    logic signed [ValW-1:0] err;
    logic signed [ValW-1:0] ctl;
    logic [DutyW-1:0]       duty;
    logic                   stop;
  } pd_res_t;

endpackage

`default_nettype wire

// File: rtl/core/encpd_in_if.sv
// Input channel of the encoder PD position drive: valid/ready plus command payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface encpd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       phase_b;

  modport source (output valid, output command, output phase_b, input ready);
  modport sink   (input valid, input command, input phase_b, output ready);
endinterface

`default_nettype wire

// File: rtl/core/encpd_out_if.sv
// Result channel of the encoder PD position drive: valid/ready plus drive status.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface encpd_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         drive_duty;
  logic               dir_forward;
  logic               dir_reverse;
  logic               stopped_flag;
  logic signed [23:0] position;
  logic signed [23:0] control_value;

  modport source (output valid, output drive_duty, output dir_forward, output dir_reverse,
                  output stopped_flag, output position, output control_value,
                  input ready);
  modport sink   (input valid, input drive_duty, input dir_forward, input dir_reverse,
                  input stopped_flag, input position, input control_value,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/encoder_pd_position_drive_core.sv
// Encoder PD position drive: counts encoder edges, runs PD steps on ticks, restarts on command, drives duty.
// Each accepted item passes the input register, then the state and result update.
// Throughput: one item per cycle while the result is taken; a stalled result holds the input.
// Reset (rst_ni low, asynchronous): count, last error, stopped flag, duty and control
// value clear; configuration returns to its defaults; both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module encoder_pd_position_drive_core
  import encpd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  encpd_in_if.sink                 in_i,
  encpd_out_if.source              out_o
);

  localparam int unsigned PosW = (COUNT_WIDTH > ValW) ? COUNT_WIDTH : ValW;
  localparam logic signed [COUNT_WIDTH-1:0] CntMax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CntMin = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic signed [PosW-1:0] PMax = PosW'(ValMax);
  localparam logic signed [PosW-1:0] PMin = PosW'(ValMin);

  cfg_t    cfg;
  pd_res_t pd;

  // Input register stage.
  logic                s1_valid_q, s1_valid_d;
  logic [CmdW-1:0]     s1_cmd_q, s1_cmd_d;
  logic                s1_phase_q, s1_phase_d;

  // Controller state; the result register is this state plus out_valid_q.
  logic signed [COUNT_WIDTH-1:0] count_q, count_d;
  logic signed [ValW-1:0]        prev_err_q, prev_err_d;
  logic                          done_q, done_d;
  logic [DutyW-1:0]              duty_q, duty_d;
  logic signed [ValW-1:0]        ctl_q, ctl_d;
  logic                          out_valid_q, out_valid_d;

  logic advance;  // result register free or being emptied this cycle
  logic step;     // stage-1 item moves into the result register

  logic signed [PosW-1:0] pos_ext;

  encpd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  encpd_pd_calc #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_calc (
    .cfg_i      (cfg),
    .count_i    (count_q),
    .prev_err_i (prev_err_q),
    .res_o      (pd)
  );

  // Pipeline flow: a result that is not taken holds, and a full input stage holds with it.
  assign advance    = !out_valid_q || out_o.ready;
  assign step       = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_cmd_d   = s1_cmd_q;
    s1_phase_d = s1_phase_q;
    if (in_i.ready) begin
      s1_valid_d = in_i.valid;
      s1_cmd_d   = in_i.command;
      s1_phase_d = in_i.phase_b;
    end
  end

  // Apply the stage-1 item to the controller state.
  always_comb begin
    count_d     = count_q;
    prev_err_d  = prev_err_q;
    done_d      = done_q;
    duty_d      = duty_q;
    ctl_d       = ctl_q;
    out_valid_d = advance ? s1_valid_q : out_valid_q;
    if (step) begin
      unique case (s1_cmd_q)
        CMD_EDGE: begin
          // Hold at the limits of the count range instead of wrapping.
          if (s1_phase_q) begin
            count_d = (count_q == CntMax) ? count_q : count_q + COUNT_WIDTH'(1);
          end else begin
            count_d = (count_q == CntMin) ? count_q : count_q - COUNT_WIDTH'(1);
          end
        end
        CMD_TICK: begin
          // A tick after the move has finished changes nothing.
          if (!done_q) begin
            prev_err_d = pd.err;
            ctl_d      = pd.ctl;
            duty_d     = pd.duty;
            done_d     = pd.stop;
          end
        end
        CMD_RESTART: begin
          // Drive and control value keep their values.
          count_d    = '0;
          prev_err_d = '0;
          done_d     = 1'b0;
        end
        default: begin
          // Unused command: report the current state.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      prev_err_q  <= '0;
      done_q      <= 1'b0;
      duty_q      <= '0;
      ctl_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      prev_err_q  <= prev_err_d;
      done_q      <= done_d;
      duty_q      <= duty_d;
      ctl_q       <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q   <= s1_cmd_d;
    s1_phase_q <= s1_phase_d;
  end

  // Report the count saturated to the 24-bit result range.
  assign pos_ext = PosW'(count_q);

  assign out_o.valid         = out_valid_q;
  assign out_o.drive_duty    = duty_q;
  assign out_o.dir_forward   = (duty_q != '0);
  assign out_o.dir_reverse   = 1'b0;
  assign out_o.stopped_flag  = done_q;
  assign out_o.position      = (pos_ext > PMax) ? ValW'(ValMax) :
                               (pos_ext < PMin) ? ValW'(ValMin) : pos_ext[ValW-1:0];
  assign out_o.control_value = ctl_q;

endmodule

`default_nettype wire

// File: rtl/core/encpd_cfg_regs.sv
// Configuration register file of the encoder PD position drive.
// Depends on encpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module encpd_cfg_regs
  import encpd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TARGET:     cfg_d.target_counts  = signed'(cfg_wdata_i);
        REG_PROP_GAIN:  cfg_d.prop_gain      = cfg_wdata_i[11:0];
        REG_DERIV_GAIN: cfg_d.deriv_gain     = cfg_wdata_i[11:0];
        REG_STOP_THR:   cfg_d.stop_threshold = cfg_wdata_i[7:0];
        REG_MIN_DUTY:   cfg_d.min_duty       = cfg_wdata_i[7:0];
        REG_MAX_DUTY:   cfg_d.max_duty       = cfg_wdata_i[7:0];
        default:        cfg_d = cfg_q;  // write beyond the list: drop
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_counts  <= TargetRst;
      cfg_q.prop_gain      <= PropGainRst;
      cfg_q.deriv_gain     <= DerivGainRst;
      cfg_q.stop_threshold <= StopThrRst;
      cfg_q.min_duty       <= MinDutyRst;
      cfg_q.max_duty       <= MaxDutyRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/encpd_pd_calc.sv
// PD step: saturated error, control value, stop decision and clamped duty.
// Depends on encpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module encpd_pd_calc
  import encpd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire cfg_t                    cfg_i,
  input  wire logic signed [COUNT_WIDTH-1:0] count_i,
  input  wire logic signed [ValW-1:0]  prev_err_i,
  output pd_res_t                      res_o
);

  localparam int unsigned DiffW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
  localparam int unsigned ErrW  = (DiffW > ValW + 1) ? DiffW : ValW + 1;
  localparam int unsigned AccW  = 39;

  localparam logic signed [ErrW-1:0] EMax = ErrW'(ValMax);
  localparam logic signed [ErrW-1:0] EMin = ErrW'(ValMin);
  localparam logic signed [AccW-1:0] AMax = AccW'(ValMax);
  localparam logic signed [AccW-1:0] AMin = AccW'(ValMin);

  logic signed [ErrW-1:0]  diff;
  logic signed [ValW-1:0]  err;
  logic signed [ValW:0]    derr;
  logic signed [36:0]      p_prod;
  logic signed [37:0]      d_prod;
  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  acc_sh;
  logic signed [ValW-1:0]  ctl;
  logic [ValW-1:0]         mag;
  logic [DutyW-1:0]        duty;

  // Error saturates to the result range before use.
  assign diff = ErrW'(cfg_i.target_counts) - ErrW'(count_i);
  assign err  = (diff > EMax) ? ValW'(ValMax) :
                (diff < EMin) ? ValW'(ValMin) : diff[ValW-1:0];

  assign derr   = (ValW+1)'(err) - (ValW+1)'(prev_err_i);
  assign p_prod = 37'(signed'({1'b0, cfg_i.prop_gain})) * 37'(err);
  assign d_prod = 38'(signed'({1'b0, cfg_i.deriv_gain})) * 38'(derr);
  assign acc    = AccW'(p_prod) + AccW'(d_prod);

  // Arithmetic shift rounds toward minus infinity.
  assign acc_sh = acc >>> 8;
  assign ctl    = (acc_sh > AMax) ? ValW'(ValMax) :
                  (acc_sh < AMin) ? ValW'(ValMin) : acc_sh[ValW-1:0];

  // Magnitude of the most negative value still fits unsigned.
  assign mag = ctl[ValW-1] ? ValW'(-ctl) : ctl;

  always_comb begin
    priority if (mag < ValW'(cfg_i.min_duty)) begin
      duty = cfg_i.min_duty;
    end else if (mag > ValW'(cfg_i.max_duty)) begin
      duty = cfg_i.max_duty;
    end else begin
      duty = mag[DutyW-1:0];
    end
  end

  assign res_o.err  = err;
  assign res_o.ctl  = ctl;
  assign res_o.stop = (mag < ValW'(cfg_i.stop_threshold));
  assign res_o.duty = res_o.stop ? '0 : duty;

endmodule

`default_nettype wire

// File: rtl/core/encpd_checker.sv
// Port-level checks for the encoder PD position drive, bound to the top level.
// Depends on encpd_pkg and encoder_pd_position_drive_core.
`timescale 1ns / 1ps
`default_nettype none

module encpd_checker
  import encpd_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [DutyW-1:0]   drive_duty_i,
  input wire logic               dir_forward_i,
  input wire logic               dir_reverse_i,
  input wire logic               stopped_flag_i,
  input wire logic signed [ValW-1:0] position_i,
  input wire logic signed [ValW-1:0] control_value_i
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(drive_duty_i)
      && $stable(stopped_flag_i) && $stable(position_i) && $stable(control_value_i))
    else $error("result changed while stalled");

  a_no_reverse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !dir_reverse_i)
    else $error("reverse drive asserted");

  a_dir_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (dir_forward_i == (drive_duty_i != '0)))
    else $error("forward line disagrees with duty");

  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && stopped_flag_i |-> (drive_duty_i == '0))
    else $error("drive active after stop");

endmodule

bind encoder_pd_position_drive_core encpd_checker u_encpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .drive_duty_i    (out_o.drive_duty),
  .dir_forward_i   (out_o.dir_forward),
  .dir_reverse_i   (out_o.dir_reverse),
  .stopped_flag_i  (out_o.stopped_flag),
  .position_i      (out_o.position),
  .control_value_i (out_o.control_value)
);

`default_nettype wire
